// ===== rtl/fba_pkg.sv =====
// Package for the frame bitmap allocator: sizes, request codes, transfer types.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int MAX_FRAMES   = 32768;
  localparam int WORD_BITS    = 32;
  localparam int MAP_WORDS    = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W      = $clog2(MAP_WORDS);
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int FRAME_W      = WADDR_W + BIT_W;
  localparam int FRAME_SHIFT  = 12;
  localparam int ADDR_W       = 32;
  localparam int ADDR_FRAME_W = ADDR_W - FRAME_SHIFT;
  localparam int LIM_W        = 16;
  localparam int LIMW_W       = WADDR_W + 1;

  localparam logic [ADDR_W-1:0] ENTRY_FLAGS = 32'h3;
  localparam logic [LIM_W-1:0]  FRAME_COUNT_RST = 16'd32768;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_MARK    = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;
  localparam logic [1:0] FUNC_TEST    = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] byte_address;
    logic [ADDR_W-1:0] entry_in;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] entry_out;
    logic              is_used;
    logic              no_frame;
    logic              bad_address;
  } out_t;

  // Status from the shared word unit
  typedef struct packed {
    logic             bit_val;
    logic             any_free;
    logic [BIT_W-1:0] free_bit;
  } wu_stat_t;

endpackage

// ===== rtl/frame_bitmap_allocator_top.sv =====
// Frame bitmap allocator: first-fit allocation, mark, release and test of 4 KiB frames.
// Mark, release and test go through access, modify and hold (out of range: access, hold);
// allocate scans the bitmap word by word, or goes straight to hold for a mapped entry.
// One item at a time, one word read per cycle; a result waits in hold on out_stall.
// Reset (rst_n low, synchronous) starts a clearing pass over all 1024 words that zeroes
// the bitmap; no item is taken until it ends, configuration writes are taken always.
`timescale 1ns / 1ps

module frame_bitmap_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fba_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fba_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fba_pkg::LIM_W-1:0]       cfg_data
);
  import fba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_SCAN0 = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_HOLD  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [WADDR_W-1:0] clr_r, clr_nxt;
  logic [WADDR_W-1:0] word_r, word_nxt;
  logic [LIM_W-1:0]   fc_r, fc_nxt;
  logic               out_valid_r, out_valid_nxt;
  in_t                req_r, req_nxt;
  out_t               res_r, res_nxt;
  out_t               out_data_r, out_data_nxt;

  logic                    ram_we;
  logic [WADDR_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0]    ram_wdata;
  logic [WADDR_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0]    ram_rdata;

  logic [WORD_BITS-1:0]    set_word, clr_word, fill_word;
  wu_stat_t                wstat;

  logic [LIM_W-1:0]        lim;
  logic [LIM_W:0]          lim_round;
  logic [LIMW_W-1:0]       lim_words;
  logic [ADDR_FRAME_W-1:0] req_frame;
  logic                    req_bad;
  logic [FRAME_W-1:0]      found_frame;
  logic [LIMW_W-1:0]       next_word;

  fba_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fba_word_unit u_word (
    .word      (ram_rdata),
    .bit_sel   (req_frame[BIT_W-1:0]),
    .set_word  (set_word),
    .clr_word  (clr_word),
    .fill_word (fill_word),
    .stat      (wstat)
  );

  assign lim         = (fc_r > LIM_W'(MAX_FRAMES)) ? LIM_W'(MAX_FRAMES) : fc_r;
  assign lim_round   = {1'b0, lim} + (LIM_W+1)'(WORD_BITS - 1);
  assign lim_words   = LIMW_W'(lim_round >> BIT_W);
  assign req_frame   = req_r.byte_address[ADDR_W-1:FRAME_SHIFT];
  assign req_bad     = req_frame >= ADDR_FRAME_W'(lim);
  assign found_frame = {word_r, wstat.free_bit};
  assign next_word   = {1'b0, word_r} + LIMW_W'(1);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    word_nxt      = word_r;
    fc_nxt        = fc_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = word_r;
    ram_wdata     = '0;
    ram_raddr     = WADDR_W'(next_word);

    if (cfg_valid) begin
      fc_nxt = cfg_data;
    end

    // drop the output once it has been transferred
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + WADDR_W'(1);
        if (clr_r == WADDR_W'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = (in_data.func == FUNC_ALLOC) ? S_SCAN0 : S_ACC;
        end
      end
      S_ACC: begin
        ram_raddr = req_frame[FRAME_W-1:BIT_W];
        if (req_bad) begin
          res_nxt   = '{entry_out: '0, is_used: 1'b0, no_frame: 1'b0, bad_address: 1'b1};
          state_nxt = S_HOLD;
        end else begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        res_nxt   = '0;
        ram_waddr = req_frame[FRAME_W-1:BIT_W];
        case (req_r.func)
          FUNC_MARK: begin
            ram_we    = 1'b1;
            ram_wdata = set_word;
          end
          FUNC_RELEASE: begin
            ram_we    = 1'b1;
            ram_wdata = clr_word;
          end
          FUNC_TEST: begin
            res_nxt.is_used = wstat.bit_val;
          end
          default: begin
          end
        endcase
        state_nxt = S_HOLD;
      end
      S_SCAN0: begin
        ram_raddr = '0;
        res_nxt   = '0;
        if (req_r.entry_in != '0) begin
          res_nxt.entry_out = req_r.entry_in;
          state_nxt         = S_HOLD;
        end else if (lim == '0) begin
          res_nxt.no_frame = 1'b1;
          state_nxt        = S_HOLD;
        end else begin
          word_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // read data is word_r; the read of the following word goes out now
        res_nxt = '0;
        if (wstat.any_free) begin
          if ((LIM_W)'(found_frame) < lim) begin
            ram_we            = 1'b1;
            ram_wdata         = fill_word;
            res_nxt.entry_out = ADDR_W'({found_frame, {FRAME_SHIFT{1'b0}}}) | ENTRY_FLAGS;
          end else begin
            res_nxt.no_frame = 1'b1;
          end
          state_nxt = S_HOLD;
        end else if (next_word >= lim_words) begin
          res_nxt.no_frame = 1'b1;
          state_nxt        = S_HOLD;
        end else begin
          word_nxt = WADDR_W'(next_word);
        end
      end
      S_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fc_r        <= FRAME_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fc_r        <= fc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/fba_ram.sv =====
// Bitmap store: one write port, one read port with registered read data.
// Depends on fba_pkg for the word count and width.
`timescale 1ns / 1ps

module fba_ram (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [fba_pkg::WADDR_W-1:0]          waddr,
  input  logic [fba_pkg::WORD_BITS-1:0]        wdata,
  input  logic [fba_pkg::WADDR_W-1:0]          raddr,
  output logic [fba_pkg::WORD_BITS-1:0]        rdata
);
  import fba_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fba_word_unit.sv =====
// Shared bitmap word unit: bit test, set, clear and lowest-free-bit search.
// Depends on fba_pkg for widths and the status struct.
`timescale 1ns / 1ps

module fba_word_unit (
  input  logic [fba_pkg::WORD_BITS-1:0] word,
  input  logic [fba_pkg::BIT_W-1:0]     bit_sel,
  output logic [fba_pkg::WORD_BITS-1:0] set_word,
  output logic [fba_pkg::WORD_BITS-1:0] clr_word,
  output logic [fba_pkg::WORD_BITS-1:0] fill_word,
  output fba_pkg::wu_stat_t             stat
);
  import fba_pkg::*;

  logic [WORD_BITS-1:0] sel_mask;
  logic [WORD_BITS-1:0] inv;
  logic [WORD_BITS-1:0] low_free;
  logic [BIT_W-1:0]     enc;

  assign sel_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
  assign inv      = ~word;
  // isolate the lowest clear bit of the word
  assign low_free = inv & (~inv + {{(WORD_BITS-1){1'b0}}, 1'b1});

  always_comb begin
    enc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_free[i]) begin
        enc = enc | BIT_W'(i);
      end
    end
  end

  assign set_word      = word | sel_mask;
  assign clr_word      = word & ~sel_mask;
  assign fill_word     = word | low_free;
  assign stat.bit_val  = |(word & sel_mask);
  assign stat.any_free = |inv;
  assign stat.free_bit = enc;

endmodule

// ===== verif/frame_bitmap_allocator_checker.sv =====
// Checker for the frame bitmap allocator: watches the request, result and frame count
// channels, keeps its own copy of the frame bitmap and compares every result.
// Depends on fba_pkg for the transfer types, sizes and request codes.
`timescale 1ns / 1ps

module frame_bitmap_allocator_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  fba_pkg::in_t             in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  fba_pkg::out_t            out_data,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [fba_pkg::LIM_W-1:0] cfg_data,
  output int                       fail_count,
  output int                       pending
);
  import fba_pkg::*;

  logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
  logic [LIM_W-1:0]     frame_count_q;
  out_t                 reply_q [$];
  int                   mismatches = 0;

  // Apply one request to the local bitmap and return the reply it should give.
  function automatic out_t serve_request(input in_t req);
    out_t             res;
    int               lim;
    int               frame;
    int               hit;
    logic [ADDR_W-1:0] frame_addr;
    res = '0;
    lim = (frame_count_q > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count_q);
    if (req.func == FUNC_ALLOC) begin
      if (req.entry_in != '0) begin
        res.entry_out = req.entry_in;
      end else begin
        hit = -1;
        // first fit: skip full words, stop at the limit even inside a word
        for (int w = 0; w < MAP_WORDS && w * WORD_BITS < lim && hit < 0; w++) begin
          if (frame_map[w] != '1) begin
            for (int b = 0; b < WORD_BITS && hit < 0; b++) begin
              if (w * WORD_BITS + b < lim && !frame_map[w][b]) hit = w * WORD_BITS + b;
            end
          end
        end
        if (hit < 0) begin
          res.no_frame = 1'b1;
        end else begin
          frame_map[hit / WORD_BITS][hit % WORD_BITS] = 1'b1;
          frame_addr = hit;
          res.entry_out = (frame_addr << FRAME_SHIFT) | ENTRY_FLAGS;
        end
      end
    end else begin
      frame = int'(req.byte_address >> FRAME_SHIFT);
      if (frame >= lim) begin
        res.bad_address = 1'b1;
      end else begin
        case (req.func)
          FUNC_MARK:    frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b1;
          FUNC_RELEASE: frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
          default:      res.is_used = frame_map[frame / WORD_BITS][frame % WORD_BITS];
        endcase
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    out_t got;
    if (!rst_n) begin
      reply_q.delete();
      frame_count_q = FRAME_COUNT_RST;
      foreach (frame_map[i]) frame_map[i] = '0;
    end else begin
      // results first: a request accepted at this edge cannot be answered at it
      if (out_valid && !out_stall) begin
        got = out_data;
        if (reply_q.size() == 0) begin
          $error("result with nothing outstanding: entry_out %h", got.entry_out);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (got.entry_out !== want.entry_out) begin
            $error("entry_out: expected %h, got %h", want.entry_out, got.entry_out);
            mismatches++;
          end
          if (got.is_used !== want.is_used) begin
            $error("is_used: expected %b, got %b", want.is_used, got.is_used);
            mismatches++;
          end
          if (got.no_frame !== want.no_frame) begin
            $error("no_frame: expected %b, got %b", want.no_frame, got.no_frame);
            mismatches++;
          end
          if (got.bad_address !== want.bad_address) begin
            $error("bad_address: expected %b, got %b", want.bad_address, got.bad_address);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) frame_count_q = cfg_data;
      if (in_valid && !in_stall) reply_q.push_back(serve_request(in_data));
    end
    pending    <= reply_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== verif/frame_bitmap_allocator_top_test.sv =====
// Top of the frame bitmap allocator test: clock, reset, request and frame count stimulus,
// random result stalls and the verdict. Needs fba_pkg, the block and the checker.
`timescale 1ns / 1ps

module frame_bitmap_allocator_top_test;
  import fba_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_t              in_data;
  logic             out_valid;
  logic             out_stall;
  out_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LIM_W-1:0] cfg_data;
  int               fail_count;
  int               pending;
  bit               calm = 1'b0;

  frame_bitmap_allocator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  frame_bitmap_allocator_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timeout set well beyond the worst case (every scan full length, longest gaps).
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly back to back or short, now and then a long hold.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  function automatic in_t mk_req(input logic [1:0] func, input logic [ADDR_W-1:0] addr,
                                 input logic [ADDR_W-1:0] entry);
    in_t r;
    r.func         = func;
    r.byte_address = addr;
    r.entry_in     = entry;
    return r;
  endfunction

  // Random request shaped around the current limit: mostly frames in range,
  // some right at the edge, the rest anywhere in the address space.
  function automatic in_t make_request(input int lim);
    in_t                     r;
    int                      pick;
    int                      span;
    int                      nf;
    logic [ADDR_FRAME_W-1:0] fr;
    r.byte_address = $urandom();
    r.entry_in     = ($urandom_range(0, 1) == 0) ? $urandom() : '0;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.func     = FUNC_ALLOC;
      r.entry_in = ($urandom_range(0, 4) == 0) ? $urandom() : '0;
    end else if (pick < 55) begin
      r.func = FUNC_MARK;
    end else if (pick < 75) begin
      r.func = FUNC_RELEASE;
    end else begin
      r.func = FUNC_TEST;
    end
    pick = $urandom_range(0, 99);
    if (lim > 0 && pick < 75) begin
      // crowd the low words so allocation has to scan past them
      span = (lim > 256 && pick < 40) ? 256 : lim;
      fr = ADDR_FRAME_W'($urandom_range(0, span - 1));
      r.byte_address[ADDR_W-1:FRAME_SHIFT] = fr;
    end else if (pick < 87) begin
      nf = lim - 1 + $urandom_range(0, 2);
      if (nf < 0) nf = 0;
      fr = ADDR_FRAME_W'(nf);
      r.byte_address[ADDR_W-1:FRAME_SHIFT] = fr;
    end
    return r;
  endfunction

  // Hold valid high across back-to-back transfers; drop it only for a gap.
  task automatic push_req(input in_t req, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_frame_count(input logic [LIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stall_gen
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = calm ? 0 : pick_idle();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [LIM_W-1:0] counts [10];
    int               lim;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset limit: whole map
    push_req(mk_req(FUNC_TEST,    32'h0000_0000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_ALLOC,   32'h0000_0000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_ALLOC,   32'h0000_0000, 32'hffff_ffff), pick_idle());
    push_req(mk_req(FUNC_ALLOC,   32'hffff_ffff, 32'h0000_0001), pick_idle());
    push_req(mk_req(FUNC_MARK,    32'h0000_1fff, 32'h0), pick_idle());
    push_req(mk_req(FUNC_TEST,    32'h0000_1000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_ALLOC,   32'h0000_0000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_RELEASE, 32'h0000_0abc, 32'h0), pick_idle());
    push_req(mk_req(FUNC_ALLOC,   32'h0000_0000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_TEST,    32'h07ff_ffff, 32'h0), pick_idle());
    push_req(mk_req(FUNC_MARK,    32'h07ff_f000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_TEST,    32'h07ff_f123, 32'h0), pick_idle());
    push_req(mk_req(FUNC_TEST,    32'h0800_0000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_MARK,    32'hffff_ffff, 32'h0), pick_idle());
    push_req(mk_req(FUNC_RELEASE, 32'hffff_f000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_RELEASE, 32'h07ff_ffff, 32'h0), pick_idle());

    // zero frames: nothing to allocate, every address out of range
    drain();
    set_frame_count('0);
    push_req(mk_req(FUNC_ALLOC,   32'h0000_0000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_TEST,    32'h0000_0000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_MARK,    32'h0000_0000, 32'h0), pick_idle());

    // three frames, all used: exhaust, free one, take it back
    drain();
    set_frame_count(16'd3);
    push_req(mk_req(FUNC_ALLOC,   32'h0000_0000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_RELEASE, 32'h0000_2000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_ALLOC,   32'h0000_0000, 32'h0), pick_idle());
    push_req(mk_req(FUNC_TEST,    32'h0000_2fff, 32'h0), pick_idle());
    push_req(mk_req(FUNC_TEST,    32'h0000_3000, 32'h0), pick_idle());

    counts = '{16'd40, 16'd32768, 16'd1, 16'd65535, 16'd33,
               16'd0, 16'd0, 16'd64, 16'd31, 16'd0};
    counts[6] = LIM_W'($urandom_range(0, 65535));
    counts[9] = LIM_W'($urandom_range(2, 300));

    // each phase starts only once every outstanding transfer has returned
    for (int p = 0; p < 10; p++) begin
      drain();
      set_frame_count(counts[p]);
      lim  = (counts[p] > MAX_FRAMES) ? MAX_FRAMES : int'(counts[p]);
      calm = (p % 4 == 2);
      for (int k = 0; k < 56; k++) push_req(make_request(lim), calm ? 0 : pick_idle());
    end

    drain();
    repeat (1030) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
